[hw/rtl/vsu_pkg.sv]
// ---------------------------------------------------------------------------
// vsu_pkg: shared types and constants of the vector slerp unit
// Pipeline item record, fixed-point formats, angle constants, arctan table.
// ---------------------------------------------------------------------------
`default_nettype none

package vsu_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int W_SQ         = 44;                 // radicand width (even)
    localparam int SQRT_STEPS   = W_SQ / 2;           // one root bit per cell
    localparam int DIV_STEPS    = FRAC_BITS + 1;      // quotient bits per lane
    localparam int W_REM        = 37;
    localparam int W_ANG        = 34;                 // Q30 CORDIC words
    localparam int ANG_FRAC     = 30;

    localparam logic [14:0] THR_RESET = 15'd16376;
    localparam logic        REG_THR   = 1'b0;         // register index (paddr[2])
    localparam logic [45:0] NEAR_ZERO_LEN2 = 46'd4;

    localparam logic signed [35:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [35:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // One item as it travels down the chain; fields are reused by later cells.
    typedef struct packed {
        logic [2:0][15:0]       f;
        logic [2:0][15:0]       t;
        logic [14:0]            alpha;
        logic                   lin;
        logic [18:0]            dot;
        logic [2:0][49:0]       wide;
        logic [2:0][21:0]       mag;
        logic [2:0]             neg;
        logic [W_SQ-1:0]        sq_n;
        logic [W_SQ-1:0]        sq_r;
        logic [21:0]            len;
        logic                   zero;
        logic [2:0][W_REM-1:0]  rem;
        logic [2:0][14:0]       q;
        logic [2:0][15:0]       dir;
        logic [15:0]            c;
        logic [W_ANG-1:0]       cx;
        logic [W_ANG-1:0]       cy;
        logic [W_ANG-1:0]       cz;
        logic                   nrot;
        logic [16:0]            co;
        logic [16:0]            si;
    } t_item;

endpackage

`default_nettype wire

[hw/rtl/vsu_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// vsu_sqrt_cell: one digit of a restoring integer square root
// Produces one root bit of sq_r from radicand remainder sq_n per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module vsu_sqrt_cell
    import vsu_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    output logic       o_vld,
    output t_item      o_item
);

    localparam logic [W_SQ:0] BIT_W = (W_SQ + 1)'(1) << (W_SQ - 2 - 2 * STEP);

    logic        r_vld;
    t_item       r_item;
    t_item       n_item;
    logic [W_SQ:0] w_try;

    always_comb begin
        n_item = i_item;
        w_try  = {1'b0, i_item.sq_r} + BIT_W;
        if ({1'b0, i_item.sq_n} >= w_try) begin
            n_item.sq_n = i_item.sq_n - w_try[W_SQ-1:0];
            n_item.sq_r = (i_item.sq_r >> 1) + BIT_W[W_SQ-1:0];
        end else begin
            n_item.sq_r = i_item.sq_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

[hw/rtl/vsu_div_cell.sv]
// ---------------------------------------------------------------------------
// vsu_div_cell: one quotient bit of three restoring dividers
// Each lane divides its remainder by the vector length, one bit per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module vsu_div_cell
    import vsu_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    output logic       o_vld,
    output t_item      o_item
);

    localparam logic [3:0] QI = 4'(BIT);

    logic             r_vld;
    t_item            r_item;
    t_item            n_item;
    logic [W_REM-1:0] w_div;
    logic [W_REM-1:0] w_lim;
    logic             w_fit;

    always_comb begin
        n_item = i_item;
        w_div  = W_REM'(i_item.len) << BIT;
        for (int k = 0; k < 3; k++) begin
            if (i_item.rem[k] >= w_div) begin
                n_item.rem[k]    = i_item.rem[k] - w_div;
                n_item.q[k][QI]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

    // restoring invariant: what is left is below the divisor at this weight
    assign w_lim = W_REM'(r_item.len) << BIT;
    assign w_fit = (r_item.rem[0] < w_lim) && (r_item.rem[1] < w_lim) &&
                   (r_item.rem[2] < w_lim);

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_item.zero |-> w_fit)
        else $error("divider remainder not reduced");

endmodule

`default_nettype wire

[hw/rtl/vsu_cordic_cell.sv]
// ---------------------------------------------------------------------------
// vsu_cordic_cell: one CORDIC micro-rotation
// Vectoring (drive y to zero) or rotation (drive z to zero) on cx/cy/cz.
// ---------------------------------------------------------------------------
`default_nettype none

module vsu_cordic_cell
    import vsu_pkg::*;
#(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_item i_item,
    output logic       o_vld,
    output t_item      o_item
);

    localparam logic [4:0]       AI     = 5'(STEP);
    localparam logic [W_ANG-1:0] W_ATAN = W_ANG'(ATAN_Q30[AI]);

    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic signed [W_ANG-1:0] w_xs;
    logic signed [W_ANG-1:0] w_ys;
    logic               w_up;

    always_comb begin
        n_item = i_item;
        w_xs   = $signed(i_item.cx) >>> STEP;
        w_ys   = $signed(i_item.cy) >>> STEP;
        if (VECTOR) begin
            w_up = $signed(i_item.cy) > 0;
        end else begin
            w_up = !i_item.cz[W_ANG-1];
        end
        if (w_up == VECTOR) begin
            n_item.cx = i_item.cx + w_ys;
            n_item.cy = i_item.cy - w_xs;
            n_item.cz = i_item.cz + W_ATAN;
        end else begin
            n_item.cx = i_item.cx - w_ys;
            n_item.cy = i_item.cy + w_xs;
            n_item.cz = i_item.cz - W_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

[hw/rtl/vector_slerp_unit.sv]
// ---------------------------------------------------------------------------
// vector_slerp_unit: spherical linear interpolation of two 3D vectors
// Q2.14 in, Q2.14 out; near-parallel pairs take lerp plus normalize.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                      contents
//  s_*       in   s_tvalid / s_tready            from, to, blend
//  m_*       out  m_tvalid / m_tready            out vector, linear_path
//  apb       in   psel, penable, pwrite, pready  parallel_threshold at 0x0
//
//  One beat per cycle while the output is not stalled; 17 single stages, two 22-cell
//  square roots, a 15-cell divider and two 16-cell CORDIC runs.
//  Reset clears only the valid bits; threshold resets to 16376.
//  A stalled output freezes the whole chain, and s_tready drops with it.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_slerp_unit
    import vsu_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, blend, 1 pad bit
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z
    output logic [47:0]       m_tdata,
    // linear_path
    output logic [0:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NS = 17;
    localparam logic signed [49:0] RND_F = 50'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [49:0] RND_Q = 50'sd1 <<< (ANG_FRAC - FRAC_BITS - 1);
    localparam logic signed [18:0] ONE19 = 19'sd1 <<< FRAC_BITS;
    localparam logic signed [49:0] SAT_HI = 50'sd32767;
    localparam logic signed [49:0] SAT_LO = -50'sd32768;

    logic [14:0] r_thr;
    logic        w_en;

    logic  r_vld  [NS];
    t_item r_item [NS];
    logic  s_vld  [NS];
    t_item s_item [NS];
    t_item n_item [NS];

    t_item n_s0, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
    t_item n_s9, n_s10, n_s11, n_s12, n_s13, n_s14, n_s15, n_s16;

    logic  sqa_vld [SQRT_STEPS+1];
    t_item sqa_item[SQRT_STEPS+1];
    logic  div_vld [DIV_STEPS+1];
    t_item div_item[DIV_STEPS+1];
    logic  sqb_vld [SQRT_STEPS+1];
    t_item sqb_item[SQRT_STEPS+1];
    logic  vec_vld [CORDIC_STEPS+1];
    t_item vec_item[CORDIC_STEPS+1];
    logic  rot_vld [CORDIC_STEPS+1];
    t_item rot_item[CORDIC_STEPS+1];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_THR) begin
            r_thr <= pwdata[14:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? {17'd0, r_thr} : 32'd0;

    // ---------------- flow control ----------------
    assign w_en     = !r_vld[NS-1] || m_tready;
    assign s_tready = w_en;

    // ---------------- stage wiring ----------------
    assign s_vld[0]  = s_tvalid;
    assign s_item[0] = '0;
    for (genvar j = 1; j < NS; j++) begin : g_link
        if (j == 6) begin : g_sqa
            assign s_vld[j]  = sqa_vld[SQRT_STEPS];
            assign s_item[j] = sqa_item[SQRT_STEPS];
        end else if (j == 7) begin : g_div
            assign s_vld[j]  = div_vld[DIV_STEPS];
            assign s_item[j] = div_item[DIV_STEPS];
        end else if (j == 9) begin : g_sqb
            assign s_vld[j]  = sqb_vld[SQRT_STEPS];
            assign s_item[j] = sqb_item[SQRT_STEPS];
        end else if (j == 10) begin : g_vec
            assign s_vld[j]  = vec_vld[CORDIC_STEPS];
            assign s_item[j] = vec_item[CORDIC_STEPS];
        end else if (j == 14) begin : g_rot
            assign s_vld[j]  = rot_vld[CORDIC_STEPS];
            assign s_item[j] = rot_item[CORDIC_STEPS];
        end else begin : g_reg
            assign s_vld[j]  = r_vld[j-1];
            assign s_item[j] = r_item[j-1];
        end
    end

    assign sqa_vld[0] = r_vld[5];   assign sqa_item[0] = r_item[5];
    assign div_vld[0] = r_vld[6];   assign div_item[0] = r_item[6];
    assign sqb_vld[0] = r_vld[8];   assign sqb_item[0] = r_item[8];
    assign vec_vld[0] = r_vld[9];   assign vec_item[0] = r_item[9];
    assign rot_vld[0] = r_vld[13];  assign rot_item[0] = r_item[13];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        vsu_sqrt_cell #(.STEP(j)) u_sqa (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_vld(sqa_vld[j]), .i_item(sqa_item[j]),
            .o_vld(sqa_vld[j+1]), .o_item(sqa_item[j+1])
        );
        vsu_sqrt_cell #(.STEP(j)) u_sqb (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_vld(sqb_vld[j]), .i_item(sqb_item[j]),
            .o_vld(sqb_vld[j+1]), .o_item(sqb_item[j+1])
        );
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_divc
        vsu_div_cell #(.BIT(DIV_STEPS - 1 - j)) u_div (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_vld(div_vld[j]), .i_item(div_item[j]),
            .o_vld(div_vld[j+1]), .o_item(div_item[j+1])
        );
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        vsu_cordic_cell #(.STEP(j), .VECTOR(1'b1)) u_vec (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_vld(vec_vld[j]), .i_item(vec_item[j]),
            .o_vld(vec_vld[j+1]), .o_item(vec_item[j+1])
        );
        vsu_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_rot (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_vld(rot_vld[j]), .i_item(rot_item[j]),
            .o_vld(rot_vld[j+1]), .o_item(rot_item[j+1])
        );
    end

    // ---------------- single stages ----------------
    // dot product terms
    always_comb begin
        logic signed [31:0] v_p;
        n_s0       = s_item[0];
        n_s0.f     = s_tdata[47:0];
        n_s0.t     = s_tdata[95:48];
        n_s0.alpha = s_tdata[110:96];
        for (int k = 0; k < 3; k++) begin
            v_p = $signed(s_tdata[16*k +: 16]) * $signed(s_tdata[48+16*k +: 16]);
            n_s0.wide[k] = 50'(v_p);
        end
    end

    // dot, path select
    always_comb begin
        logic signed [33:0] v_sum;
        logic signed [33:0] v_dot;
        logic [18:0]        v_mdot;
        n_s1   = s_item[1];
        v_sum  = $signed(s_item[1].wide[0][33:0]) + $signed(s_item[1].wide[1][33:0]) +
                 $signed(s_item[1].wide[2][33:0]);
        v_dot  = 34'((50'(v_sum) + RND_F) >>> FRAC_BITS);
        v_mdot = v_dot[33] ? 19'(-v_dot) : 19'(v_dot);
        n_s1.dot = 19'(v_dot);
        n_s1.lin = v_mdot > 19'(r_thr);
    end

    // lerp: (to - from) * blend; slerp: from * dot
    always_comb begin
        logic signed [19:0] v_a;
        logic signed [19:0] v_b;
        logic signed [39:0] v_p;
        n_s2 = s_item[2];
        for (int k = 0; k < 3; k++) begin
            if (s_item[2].lin) begin
                v_a = 20'($signed(s_item[2].t[k])) - 20'($signed(s_item[2].f[k]));
                v_b = $signed({5'd0, s_item[2].alpha});
            end else begin
                v_a = 20'($signed(s_item[2].f[k]));
                v_b = 20'($signed(s_item[2].dot));
            end
            v_p = v_a * v_b;
            n_s2.wide[k] = 50'(v_p);
        end
    end

    // vector to normalize
    always_comb begin
        logic signed [25:0] v_r;
        logic signed [25:0] v_v;
        n_s3 = s_item[3];
        for (int k = 0; k < 3; k++) begin
            v_r = 26'((50'($signed(s_item[3].wide[k][39:0])) + RND_F) >>> FRAC_BITS);
            if (s_item[3].lin) begin
                v_v = 26'($signed(s_item[3].f[k])) + v_r;
            end else begin
                v_v = 26'($signed(s_item[3].t[k])) - v_r;
            end
            n_s3.neg[k] = v_v[25];
            n_s3.mag[k] = v_v[25] ? 22'(-v_v) : 22'(v_v);
        end
    end

    always_comb begin
        logic [43:0] v_sq;
        n_s4 = s_item[4];
        for (int k = 0; k < 3; k++) begin
            v_sq = s_item[4].mag[k] * s_item[4].mag[k];
            n_s4.wide[k] = 50'(v_sq);
        end
    end

    always_comb begin
        logic [45:0] v_len2;
        n_s5   = s_item[5];
        v_len2 = 46'(s_item[5].wide[0][43:0]) + 46'(s_item[5].wide[1][43:0]) +
                 46'(s_item[5].wide[2][43:0]);
        n_s5.sq_n = v_len2[W_SQ-1:0];
        n_s5.sq_r = '0;
        n_s5.zero = v_len2 < NEAR_ZERO_LEN2;
    end

    // divider setup: round half away from zero on magnitudes
    always_comb begin
        n_s6     = s_item[6];
        n_s6.len = s_item[6].sq_r[21:0];
        n_s6.q   = '0;
        for (int k = 0; k < 3; k++) begin
            n_s6.rem[k] = (W_REM'(s_item[6].mag[k]) << FRAC_BITS) +
                          W_REM'(s_item[6].sq_r[21:1]);
        end
    end

    // unit direction; clamp dot for acos
    always_comb begin
        logic signed [15:0] v_q;
        logic signed [15:0] v_c;
        logic signed [31:0] v_cc;
        n_s7 = s_item[7];
        for (int k = 0; k < 3; k++) begin
            v_q = 16'(s_item[7].q[k]);
            if (s_item[7].zero) begin
                n_s7.dir[k] = '0;
            end else if (s_item[7].neg[k]) begin
                n_s7.dir[k] = -v_q;
            end else begin
                n_s7.dir[k] = v_q;
            end
        end
        if ($signed(s_item[7].dot) > ONE19) begin
            v_c = 16'(ONE19);
        end else if ($signed(s_item[7].dot) < -ONE19) begin
            v_c = 16'(-ONE19);
        end else begin
            v_c = 16'(s_item[7].dot);
        end
        v_cc         = v_c * v_c;
        n_s7.c       = v_c;
        n_s7.wide[0] = 50'(v_cc);
    end

    always_comb begin
        n_s8      = s_item[8];
        n_s8.sq_n = (W_SQ'(1) << (2 * FRAC_BITS)) - s_item[8].wide[0][W_SQ-1:0];
        n_s8.sq_r = '0;
    end

    // acos start vector (c, s); negative c pre-rotated by a quarter turn
    always_comb begin
        logic signed [W_ANG-1:0] v_xc;
        logic signed [W_ANG-1:0] v_ys;
        n_s9 = s_item[9];
        v_xc = W_ANG'($signed(s_item[9].c)) <<< (ANG_FRAC - FRAC_BITS);
        v_ys = $signed(s_item[9].sq_r[W_ANG-1:0]) <<< (ANG_FRAC - FRAC_BITS);
        if (s_item[9].c[15]) begin
            n_s9.cx = v_ys;
            n_s9.cy = -v_xc;
            n_s9.cz = W_ANG'(ANG_HALF_PI);
        end else begin
            n_s9.cx = v_xc;
            n_s9.cy = v_ys;
            n_s9.cz = '0;
        end
    end

    always_comb begin
        logic signed [49:0] v_m;
        n_s10 = s_item[10];
        v_m   = $signed(s_item[10].cz) * $signed({1'b0, s_item[10].alpha});
        n_s10.wide[0] = v_m;
    end

    // theta into [0, 2pi)
    always_comb begin
        logic signed [35:0] v_th;
        n_s11 = s_item[11];
        v_th  = 36'(($signed(s_item[11].wide[0]) + RND_F) >>> FRAC_BITS);
        if (v_th < 0) begin
            v_th = v_th + ANG_TWO_PI;
        end else if (v_th >= ANG_TWO_PI) begin
            v_th = v_th - ANG_TWO_PI;
        end
        n_s11.cz = v_th[W_ANG-1:0];
    end

    always_comb begin
        logic signed [35:0] v_r;
        n_s12 = s_item[12];
        v_r   = 36'($signed(s_item[12].cz));
        if (v_r > ANG_PI) begin
            v_r = v_r - ANG_TWO_PI;
        end
        n_s12.cz = v_r[W_ANG-1:0];
    end

    // fold into the right half plane, flip sign of the result later
    always_comb begin
        logic signed [35:0] v_r;
        n_s13 = s_item[13];
        v_r   = 36'($signed(s_item[13].cz));
        n_s13.nrot = 1'b0;
        if (v_r > ANG_HALF_PI) begin
            v_r        = v_r - ANG_PI;
            n_s13.nrot = 1'b1;
        end else if (v_r < -ANG_HALF_PI) begin
            v_r        = v_r + ANG_PI;
            n_s13.nrot = 1'b1;
        end
        n_s13.cz = v_r[W_ANG-1:0];
        n_s13.cx = CORDIC_GAIN;
        n_s13.cy = '0;
    end

    always_comb begin
        logic signed [34:0] v_x;
        logic signed [34:0] v_y;
        n_s14 = s_item[14];
        v_x   = 35'($signed(s_item[14].cx));
        v_y   = 35'($signed(s_item[14].cy));
        if (s_item[14].nrot) begin
            v_x = -v_x;
            v_y = -v_y;
        end
        n_s14.co = 17'((50'(v_x) + RND_Q) >>> (ANG_FRAC - FRAC_BITS));
        n_s14.si = 17'((50'(v_y) + RND_Q) >>> (ANG_FRAC - FRAC_BITS));
    end

    always_comb begin
        logic signed [33:0] v_acc;
        n_s15 = s_item[15];
        for (int k = 0; k < 3; k++) begin
            v_acc = $signed(s_item[15].f[k]) * $signed(s_item[15].co) +
                    $signed(s_item[15].dir[k]) * $signed(s_item[15].si);
            n_s15.wide[k] = 50'(v_acc);
        end
    end

    // result: rounded, saturated; lerp path passes the unit vector
    always_comb begin
        logic signed [49:0] v_res;
        n_s16 = s_item[16];
        for (int k = 0; k < 3; k++) begin
            v_res = ($signed(s_item[16].wide[k]) + RND_F) >>> FRAC_BITS;
            if (!s_item[16].lin) begin
                if (v_res > SAT_HI) begin
                    n_s16.dir[k] = 16'(SAT_HI);
                end else if (v_res < SAT_LO) begin
                    n_s16.dir[k] = 16'(SAT_LO);
                end else begin
                    n_s16.dir[k] = 16'(v_res);
                end
            end
        end
    end

    assign n_item[0]  = n_s0;   assign n_item[1]  = n_s1;   assign n_item[2]  = n_s2;
    assign n_item[3]  = n_s3;   assign n_item[4]  = n_s4;   assign n_item[5]  = n_s5;
    assign n_item[6]  = n_s6;   assign n_item[7]  = n_s7;   assign n_item[8]  = n_s8;
    assign n_item[9]  = n_s9;   assign n_item[10] = n_s10;  assign n_item[11] = n_s11;
    assign n_item[12] = n_s12;  assign n_item[13] = n_s13;  assign n_item[14] = n_s14;
    assign n_item[15] = n_s15;  assign n_item[16] = n_s16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            for (int j = 0; j < NS; j++) begin
                r_vld[j] <= s_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NS; j++) begin
                r_item[j] <= n_item[j];
            end
        end
    end

    assign m_tvalid   = r_vld[NS-1];
    assign m_tdata    = r_item[NS-1].dir;
    assign m_tuser[0] = r_item[NS-1].lin;

    // ---------------- checks ----------------
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_lerp_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |->
            $signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
            $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
            $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384)
        else $error("normalized component beyond one");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-2] && m_tvalid && !m_tready |=> r_vld[NS-2])
        else $error("chain advanced while output stalled");

endmodule

`default_nettype wire

[tb/sv/vector_slerp_unit_test.sv]
// ---------------------------------------------------------------------------
// vector_slerp_unit_test: self-checking bench for the vector slerp unit
// Streams vector pairs through the block, with random stalls on both sides in all phases but the last.
// Each accepted beat is predicted by a bit-exact fixed-point slerp/lerp model.
// Results are checked in order. The threshold register is swept between
// phases while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_slerp_unit_test;
    import vsu_pkg::*;

    localparam logic [2:0] THR_ADDR   = 3'd0;
    localparam int         DRAIN_CYC  = 130;
    localparam int         MAX_CYCLES = 400000;
    localparam longint     ONE_Q      = 64'sd1 <<< FRAC_BITS;

    typedef longint t_vec3 [3];
    typedef struct {
        logic [47:0] vec;
        logic        lin;
    } t_slerp_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    vector_slerp_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [111:0] pend_beats [$];
    t_slerp_res   exp_results [$];
    logic [14:0]  thr_model;
    int           src_idle;
    int           snk_idle;
    int           n_errors;
    int           n_sent;
    int           n_checked;
    int           n_lin;
    int           cycles;

    // ---------------- fixed-point predictor ----------------
    function automatic longint rnd_q(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void unit_len(input t_vec3 v, output t_vec3 o);
        longint unsigned len2;
        longint unsigned len;
        longint unsigned mag;
        longint          q;
        len2 = 0;
        for (int k = 0; k < 3; k++) len2 += longint'(v[k] * v[k]);
        if (len2 < 4) begin
            for (int k = 0; k < 3; k++) o[k] = 0;
            return;
        end
        len = floor_sqrt(len2);
        for (int k = 0; k < 3; k++) begin
            mag = (v[k] < 0) ? -v[k] : v[k];
            q = ((mag << FRAC_BITS) + len / 2) / len;
            o[k] = (v[k] < 0) ? -q : q;
        end
    endfunction

    function automatic longint arccos_q30(longint c);
        longint s, x, y, z, t, xo;
        z = 0;
        if (c > ONE_Q) c = ONE_Q;
        if (c < -ONE_Q) c = -ONE_Q;
        s = floor_sqrt(ONE_Q * ONE_Q - c * c);
        x = c <<< (30 - FRAC_BITS);
        y = s <<< (30 - FRAC_BITS);
        if (x < 0) begin
            t = x; x = y; y = -t; z = ANG_HALF_PI;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xo = x;
            if (y > 0) begin
                x = x + (y >>> i); y = y - (xo >>> i); z = z + longint'(ATAN_Q30[i]);
            end else begin
                x = x - (y >>> i); y = y + (xo >>> i); z = z - longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function automatic void rotate_q30(input longint a, output longint co, output longint si);
        longint r, x, y, xo;
        bit     neg;
        r = a % longint'(ANG_TWO_PI);
        x = CORDIC_GAIN;
        y = 0;
        neg = 0;
        if (r < 0) r += ANG_TWO_PI;
        if (r > ANG_PI) r -= ANG_TWO_PI;
        if (r > ANG_HALF_PI) begin
            r -= ANG_PI; neg = 1;
        end else if (r < -longint'(ANG_HALF_PI)) begin
            r += ANG_PI; neg = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xo = x;
            if (r >= 0) begin
                x = x - (y >>> i); y = y + (xo >>> i); r = r - longint'(ATAN_Q30[i]);
            end else begin
                x = x + (y >>> i); y = y - (xo >>> i); r = r + longint'(ATAN_Q30[i]);
            end
        end
        co = neg ? -x : x;
        si = neg ? -y : y;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_slerp_res slerp_predict(logic [111:0] d, logic [14:0] thr);
        t_vec3      f, t, v, res, dir;
        longint     alpha, dot, mdot, theta, co, si;
        t_slerp_res r;
        for (int k = 0; k < 3; k++) begin
            f[k] = longint'($signed(d[16*k +: 16]));
            t[k] = longint'($signed(d[48 + 16*k +: 16]));
        end
        alpha = d[110:96];
        dot = rnd_q(f[0] * t[0] + f[1] * t[1] + f[2] * t[2], FRAC_BITS);
        mdot = (dot < 0) ? -dot : dot;
        r.lin = mdot > longint'(thr);
        if (r.lin) begin
            for (int k = 0; k < 3; k++)
                v[k] = f[k] + rnd_q((t[k] - f[k]) * alpha, FRAC_BITS);
            unit_len(v, res);
        end else begin
            theta = rnd_q(arccos_q30(dot) * alpha, FRAC_BITS);
            rotate_q30(theta, co, si);
            co = rnd_q(co, 30 - FRAC_BITS);
            si = rnd_q(si, 30 - FRAC_BITS);
            for (int k = 0; k < 3; k++) v[k] = t[k] - rnd_q(f[k] * dot, FRAC_BITS);
            unit_len(v, dir);
            for (int k = 0; k < 3; k++) res[k] = rnd_q(f[k] * co + dir[k] * si, FRAC_BITS);
        end
        r.vec = {clip16(res[2]), clip16(res[1]), clip16(res[0])};
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_beat(int fx, int fy, int fz, int tx, int ty, int tz, int bl);
        pend_beats.push_back({1'b0, bl[14:0], tz[15:0], ty[15:0], tx[15:0],
                              fz[15:0], fy[15:0], fx[15:0]});
    endtask

    task automatic rand_unit(output int x, output int y, output int z);
        real a, b, c, l;
        a = real'($urandom_range(2000)) - 1000.0;
        b = real'($urandom_range(2000)) - 1000.0;
        c = real'($urandom_range(2000)) - 1000.0;
        l = $sqrt(a * a + b * b + c * c);
        if (l < 1.0) begin
            a = 1.0; l = 1.0;
        end
        x = $rtoi(a / l * 16384.0);
        y = $rtoi(b / l * 16384.0);
        z = $rtoi(c / l * 16384.0);
    endtask

    function automatic int rand_blend();
        case ($urandom_range(9))
            0: return 0;
            1: return 16384;
            default: return $urandom_range(16384);
        endcase
    endfunction

    task automatic fill_random(int n);
        int fx, fy, fz, tx, ty, tz, sel, sg;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            rand_unit(fx, fy, fz);
            if (sel < 65) begin
                rand_unit(tx, ty, tz);
            end else if (sel < 85) begin
                // near-parallel or near-antiparallel pair
                sg = $urandom_range(1) ? 1 : -1;
                tx = sg * fx + $urandom_range(80) - 40;
                ty = sg * fy + $urandom_range(80) - 40;
                tz = sg * fz + $urandom_range(80) - 40;
            end else begin
                fx = $urandom; fy = $urandom; fz = $urandom;
                tx = $urandom; ty = $urandom; tz = $urandom;
            end
            push_beat(fx, fy, fz, tx, ty, tz, rand_blend());
        end
    endtask

    task automatic wait_idle();
        while (pend_beats.size() != 0 || s_tvalid || exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_thr(logic [14:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= THR_ADDR;
        pwdata  <= {17'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_model = val;
    endtask

    // ---------------- clock, reset, sequencing ----------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        logic [14:0] thr_list [5];
        thr_list = '{15'd16376, 15'd0, 15'd16384, 15'd12000, 15'd16376};
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        thr_model = THR_RESET;
        src_idle  = 19;
        snk_idle  = 67;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: parallel, antiparallel, orthogonal, extremes, zero, overlong
        push_beat(16384, 0, 0, 16384, 0, 0, 8192);
        push_beat(16384, 0, 0, -16384, 0, 0, 8192);
        push_beat(16384, 0, 0, 0, 16384, 0, 0);
        push_beat(16384, 0, 0, 0, 16384, 0, 16384);
        push_beat(16384, 0, 0, 0, 16384, 0, 8192);
        push_beat(0, 0, 16384, 0, -16384, 0, 4096);
        push_beat(32767, 32767, 32767, 32767, 32767, 32767, 16384);
        push_beat(-32768, -32768, -32768, -32768, -32768, -32768, 0);
        push_beat(32767, -32768, 32767, -32768, 32767, -32768, 12345);
        push_beat(0, 0, 0, 0, 0, 0, 8192);
        push_beat(0, 0, 0, 16384, 0, 0, 16384);
        push_beat(16384, 0, 0, 0, 0, 0, 8192);
        push_beat(16384, 0, 0, 16383, 181, 0, 16384);
        push_beat(16384, 0, 0, -16383, 0, 181, 1);
        push_beat(16384, 0, 0, 16384, 1, 0, 16384);
        push_beat(1, 0, 0, 1, 0, 0, 16384);
        push_beat(11585, 11585, 0, -11585, 11585, 0, 16383);
        push_beat(16384, 0, 0, 16384, 0, 0, 0);
        push_beat(0, 16384, 0, 0, 16384, 1, 16384);
        push_beat(9459, 9459, 9459, -9459, -9459, -9459, 8191);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) begin
                src_idle = 67; snk_idle = 19;
            end else if (ph == 4) begin
                src_idle = 0; snk_idle = 0;
            end
            if (ph != 0) write_thr(thr_list[ph]);
            fill_random(130);
            wait_idle();
        end

        $display("Checked %0d results from %0d beats (%0d on the lerp path),",
                 n_checked, n_sent, n_lin);
        $display("over five threshold phases and three stall patterns.");
        if (n_errors == 0 && exp_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            n_sent   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_results.push_back(slerp_predict(s_tdata, thr_model));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pend_beats.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_tdata  <= pend_beats.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_slerp_res e;
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            n_errors  <= 0;
            n_checked <= 0;
            n_lin     <= 0;
            cycles    <= 0;
        end else begin
            cycles   <= cycles + 1;
            m_tready <= ($urandom_range(99) >= snk_idle);
            if (m_tvalid && m_tready) begin
                n_checked <= n_checked + 1;
                if (exp_results.size() == 0) begin
                    if (n_errors < 10)
                        $display("ERROR: unexpected beat data=%h lin=%b", m_tdata, m_tuser);
                    n_errors <= n_errors + 1;
                end else begin
                    e = exp_results.pop_front();
                    if (e.lin) n_lin <= n_lin + 1;
                    if (m_tdata !== e.vec || m_tuser[0] !== e.lin) begin
                        if (n_errors < 10)
                            $display({"ERROR: beat %0d exp x=%h y=%h z=%h lin=%b",
                                      " got x=%h y=%h z=%h lin=%b"},
                                     n_checked, e.vec[15:0], e.vec[31:16], e.vec[47:32], e.lin,
                                     m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]);
                        n_errors <= n_errors + 1;
                    end
                end
            end
            if (cycles > MAX_CYCLES) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
